[hw/rtl/pcd_pkg.sv]
// types, constants and helper functions for the percent decoder
// used by pcd_front, pcd_queue, pcd_back and percent_decoder_core
package pcd_pkg;

   localparam logic [7:0] PCT_CHAR = 8'h25;
   localparam int GROUP_MAX = 3;
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_decoded;
      logic       out_last;
   } rsp_item_type;

   // up to three results caused by one request, oldest in item[0]
   typedef struct packed {
      logic [1:0]                     count;
      rsp_item_type [GROUP_MAX-1:0]   item;
   } group_type;

   typedef enum logic [1:0] {
      HELD_NONE  = 2'd0,
      HELD_PCT   = 2'd1,
      HELD_DIGIT = 2'd2
   } held_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   function automatic hex_type hex_digit(input logic [7:0] b);
      hex_type h;
      h.ok  = 1'b1;
      h.val = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h.val = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h.val = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h.val = 4'(b - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

[hw/rtl/percent_decoder_core.sv]
// top level of the percent decoder: front end, group queue and back end
// depends on pcd_pkg, pcd_front, pcd_queue and pcd_back
//
// Decodes a URI-style byte stream: "%" plus two hex digits with a nonzero value
// becomes one byte flagged out_decoded; anything else passes through as literal
// bytes, and a "%" can reopen an escape. A request is accepted every cycle as
// long as the group queue (four entries) has room, and nothing leaves the
// front for a byte that only extends an open escape. Each request yields zero
// to three results, which the back end hands out one per cycle from a
// registered output while the receiver pops; a failed escape yields up to three
// results. A group passes through a queue slot and then the output register.
module percent_decoder_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  pcd_pkg::req_item_type req_data,
   output logic                  empty,
   input  logic                  pop,
   output pcd_pkg::rsp_item_type rsp_data
);

   logic               q_push, q_pop, q_full, q_empty;
   pcd_pkg::group_type q_in, q_head;

   pcd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in)
   );

   pcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .empty     (q_empty),
      .full      (q_full),
      .head      (q_head)
   );

   pcd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("group pushed into full queue");

   a_no_empty_group: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_in.count != 2'd0))
      else $error("empty group queued");

   a_decoded_nonzero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.out_decoded) |-> (rsp_data.out_byte != 8'd0))
      else $error("decoded byte is zero");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result pending after reset");
`endif

endmodule

[hw/rtl/pcd_front.sv]
// front end: takes raw bytes, tracks an open escape and classifies each request
// into a group of up to three results; depends on pcd_pkg
module pcd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  pcd_pkg::req_item_type req_data,
   input  logic                  q_full,
   output logic                  q_push,
   output pcd_pkg::group_type    q_data
);

   pcd_pkg::held_type held_ff, held_in;
   logic [7:0]        digit_ff, digit_in;
   logic              accept;
   pcd_pkg::hex_type  hex_new, hex_old;
   logic [7:0]        value;
   logic              is_pct;
   logic [7:0]        b;
   logic              last;

   assign full    = q_full;
   assign accept  = push && !q_full;
   assign b       = req_data.in_byte;
   assign last    = req_data.in_last;
   assign is_pct  = (b == pcd_pkg::PCT_CHAR);
   assign hex_new = pcd_pkg::hex_digit(b);
   assign hex_old = pcd_pkg::hex_digit(digit_ff);
   assign value   = (hex_new.ok && hex_old.ok) ? {hex_old.val, hex_new.val} : 8'd0;

   // next state
   always_comb begin
      held_in  = held_ff;
      digit_in = digit_ff;
      if (accept) begin
         case (held_ff)
            pcd_pkg::HELD_PCT: begin
               if (last) begin
                  held_in = pcd_pkg::HELD_NONE;
               end else if (is_pct) begin
                  held_in = pcd_pkg::HELD_PCT;
               end else if (hex_new.ok) begin
                  held_in  = pcd_pkg::HELD_DIGIT;
                  digit_in = b;
               end else begin
                  held_in = pcd_pkg::HELD_NONE;
               end
            end
            pcd_pkg::HELD_DIGIT: begin
               if (value == 8'd0 && is_pct && !last) begin
                  held_in = pcd_pkg::HELD_PCT;
               end else begin
                  held_in = pcd_pkg::HELD_NONE;
               end
            end
            default: begin
               if (is_pct && !last) begin
                  held_in = pcd_pkg::HELD_PCT;
               end else begin
                  held_in = pcd_pkg::HELD_NONE;
               end
            end
         endcase
      end
   end

   // result group for this request
   always_comb begin
      q_data = '0;
      case (held_ff)
         pcd_pkg::HELD_PCT: begin
            q_data.item[0].out_byte = pcd_pkg::PCT_CHAR;
            if (last) begin
               q_data.count            = 2'd2;
               q_data.item[1].out_byte = b;
               q_data.item[1].out_last = 1'b1;
            end else if (is_pct) begin
               q_data.count = 2'd1;
            end else if (hex_new.ok) begin
               q_data.count = 2'd0;
            end else begin
               q_data.count            = 2'd2;
               q_data.item[1].out_byte = b;
            end
         end
         pcd_pkg::HELD_DIGIT: begin
            if (value != 8'd0) begin
               q_data.count               = 2'd1;
               q_data.item[0].out_byte    = value;
               q_data.item[0].out_decoded = 1'b1;
               q_data.item[0].out_last    = last;
            end else begin
               // failed escape: '%' and the held digit go out as literals
               q_data.item[0].out_byte = pcd_pkg::PCT_CHAR;
               q_data.item[1].out_byte = digit_ff;
               if (is_pct && !last) begin
                  q_data.count = 2'd2;
               end else begin
                  q_data.count            = 2'd3;
                  q_data.item[2].out_byte = b;
                  q_data.item[2].out_last = last;
               end
            end
         end
         default: begin
            if (is_pct && !last) begin
               q_data.count = 2'd0;
            end else begin
               q_data.count            = 2'd1;
               q_data.item[0].out_byte = b;
               q_data.item[0].out_last = last;
            end
         end
      endcase
   end

   assign q_push = accept && (q_data.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= pcd_pkg::HELD_NONE;
      end else begin
         held_ff <= held_in;
      end
      digit_ff <= digit_in;
   end

endmodule

[hw/rtl/pcd_queue.sv]
// short queue of result groups between the front and the back end
// depends on pcd_pkg
module pcd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pcd_pkg::group_type push_data,
   input  logic               pop,
   output logic               empty,
   output logic               full,
   output pcd_pkg::group_type head
);

   localparam int PTR_W = (pcd_pkg::QUEUE_DEPTH > 1) ? $clog2(pcd_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(pcd_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(pcd_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(pcd_pkg::QUEUE_DEPTH);

   pcd_pkg::group_type slot_ff [pcd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == FULL_CNT);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/pcd_back.sv]
// back end: walks each queued group one result per cycle
// into the output register while it is free; depends on pcd_pkg
module pcd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  pcd_pkg::group_type    q_head,
   output logic                  q_pop,
   output logic                  empty,
   input  logic                  pop,
   output pcd_pkg::rsp_item_type rsp_data
);

   logic                  valid_ff, valid_in;
   pcd_pkg::rsp_item_type item_ff, item_in;
   logic [1:0]            idx_ff, idx_in;
   logic                  load;
   logic                  group_done;

   assign empty      = !valid_ff;
   assign rsp_data   = item_ff;
   // output register is free when empty or being taken this cycle
   assign load       = (!valid_ff || pop) && !q_empty;
   assign group_done = (idx_ff == q_head.count - 2'd1);
   assign q_pop      = load && group_done;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = q_head.item[idx_ff];
         idx_in   = group_done ? 2'd0 : idx_ff + 2'd1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      item_ff <= item_in;
   end

endmodule

[dv/tb_percent_decoder_core.sv]
// self-checking testbench for percent_decoder_core: directed and random byte streams
// with bursty requests and a stalling receiver, checked against an in-bench decoder
// depends on pcd_pkg and the percent_decoder_core rtl
module tb_percent_decoder_core;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 300;
   localparam int DRAIN_CYCLES = 12;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  pop = 1'b0;
   logic                  full;
   logic                  empty;
   pcd_pkg::req_item_type req_data = '0;
   pcd_pkg::rsp_item_type rsp_data;

   pcd_pkg::req_item_type pending_reqs[$];
   pcd_pkg::rsp_item_type expected_bytes[$];

   // decoder state mirrored in the bench
   pcd_pkg::held_type esc_state = pcd_pkg::HELD_NONE;
   logic [7:0]        esc_digit = 8'h00;

   int error_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   int drain_run = 0;
   int hold_run = 0;

   percent_decoder_core uut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // -1 when the byte is not a hex digit
   function automatic int nibble_of(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b) - int'("0");
      if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
      if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
      return -1;
   endfunction

   function automatic void push_expected(logic [7:0] b, logic dec, logic last);
      pcd_pkg::rsp_item_type r;
      r.out_byte    = b;
      r.out_decoded = dec;
      r.out_last    = last;
      expected_bytes.push_back(r);
   endfunction

   function automatic void decode_request(pcd_pkg::req_item_type r);
      int         hi;
      int         lo;
      logic [7:0] v;
      case (esc_state)
         pcd_pkg::HELD_PCT: begin
            if (r.in_last) begin
               push_expected(pcd_pkg::PCT_CHAR, 1'b0, 1'b0);
               push_expected(r.in_byte, 1'b0, 1'b1);
               esc_state = pcd_pkg::HELD_NONE;
            end else if (r.in_byte == pcd_pkg::PCT_CHAR) begin
               // the old '%' goes out literally, the new one opens an escape
               push_expected(pcd_pkg::PCT_CHAR, 1'b0, 1'b0);
            end else if (nibble_of(r.in_byte) >= 0) begin
               esc_digit = r.in_byte;
               esc_state = pcd_pkg::HELD_DIGIT;
            end else begin
               push_expected(pcd_pkg::PCT_CHAR, 1'b0, 1'b0);
               push_expected(r.in_byte, 1'b0, 1'b0);
               esc_state = pcd_pkg::HELD_NONE;
            end
         end
         pcd_pkg::HELD_DIGIT: begin
            hi = nibble_of(esc_digit);
            lo = nibble_of(r.in_byte);
            v = 8'h00;
            if (hi >= 0 && lo >= 0) v = {hi[3:0], lo[3:0]};
            if (v != 8'h00) begin
               push_expected(v, 1'b1, r.in_last);
               esc_state = pcd_pkg::HELD_NONE;
            end else begin
               push_expected(pcd_pkg::PCT_CHAR, 1'b0, 1'b0);
               push_expected(esc_digit, 1'b0, 1'b0);
               if (r.in_byte == pcd_pkg::PCT_CHAR && !r.in_last) begin
                  esc_state = pcd_pkg::HELD_PCT;
               end else begin
                  push_expected(r.in_byte, 1'b0, r.in_last);
                  esc_state = pcd_pkg::HELD_NONE;
               end
            end
         end
         default: begin
            if (r.in_byte == pcd_pkg::PCT_CHAR && !r.in_last) begin
               esc_state = pcd_pkg::HELD_PCT;
            end else begin
               push_expected(r.in_byte, 1'b0, r.in_last);
               esc_state = pcd_pkg::HELD_NONE;
            end
         end
      endcase
   endfunction

   function automatic void add_req(logic [7:0] b, logic last);
      pcd_pkg::req_item_type r;
      r.in_byte = b;
      r.in_last = last;
      pending_reqs.push_back(r);
   endfunction

   function automatic logic [7:0] rand_hex_char();
      int k;
      k = $urandom_range(0, 21);
      if (k < 10) return 8'(8'h30 + k);
      if (k < 16) return 8'(8'h61 + k - 10);
      return 8'(8'h41 + k - 16);
   endfunction

   function automatic logic [7:0] rand_non_hex();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (nibble_of(b) >= 0 || b == pcd_pkg::PCT_CHAR);
      return b;
   endfunction

   // one component: a few escapes, broken escapes and literals, last flag on the end
   function automatic void add_component();
      logic [7:0] text[$];
      logic [7:0] hi;
      logic [7:0] lo;
      int         tokens;
      tokens = $urandom_range(1, 5);
      repeat (tokens) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               do begin
                  hi = rand_hex_char();
                  lo = rand_hex_char();
               end while (hi == "0" && lo == "0");
               text.push_back(pcd_pkg::PCT_CHAR);
               text.push_back(hi);
               text.push_back(lo);
            end
            4: begin
               text.push_back(pcd_pkg::PCT_CHAR);
               text.push_back("0");
               text.push_back("0");
            end
            5: begin
               text.push_back(pcd_pkg::PCT_CHAR);
               text.push_back(rand_non_hex());
            end
            6: begin
               text.push_back(pcd_pkg::PCT_CHAR);
               text.push_back(rand_hex_char());
               text.push_back($urandom_range(0, 1) ? pcd_pkg::PCT_CHAR : rand_non_hex());
            end
            7: begin
               text.push_back(pcd_pkg::PCT_CHAR);
               text.push_back(pcd_pkg::PCT_CHAR);
            end
            default: text.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      // escape cut short by the end of the component
      case ($urandom_range(0, 7))
         0: text.push_back(pcd_pkg::PCT_CHAR);
         1: begin
            text.push_back(pcd_pkg::PCT_CHAR);
            text.push_back(rand_hex_char());
         end
         default: ;
      endcase
      foreach (text[i]) add_req(text[i], i == text.size() - 1);
   endfunction

   // request driver: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            void'(pending_reqs.pop_front());
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            push <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            push <= 1'b1;
            req_data <= pending_reqs[0];
         end else begin
            push <= 1'b0;
         end
      end
   end

   // receiver: runs of pops alternating with stalls, sometimes no stall at all
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (drain_run > 0) begin
         drain_run--;
         pop <= 1'b1;
      end else if (hold_run > 0) begin
         hold_run--;
         pop <= 1'b0;
      end else begin
         drain_run = $urandom_range(1, 24);
         hold_run = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         pop <= 1'b1;
      end
   end

   // monitor: check popped results, then predict from the accepted request
   always @(posedge clock) begin
      pcd_pkg::rsp_item_type want;
      if (!reset) begin
         if (pop && !empty) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected result: out_byte %h", rsp_data.out_byte);
               error_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, got %h", want.out_byte, rsp_data.out_byte);
                  error_count++;
               end
               if (rsp_data.out_decoded !== want.out_decoded) begin
                  $error("out_decoded: expected %b, got %b",
                         want.out_decoded, rsp_data.out_decoded);
                  error_count++;
               end
               if (rsp_data.out_last !== want.out_last) begin
                  $error("out_last: expected %b, got %b", want.out_last, rsp_data.out_last);
                  error_count++;
               end
            end
         end
         if (push && !full) decode_request(req_data);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("percent_decoder_core regression: fail");
         $finish;
      end
   end

   initial begin
      int target;
      // a valid escape
      add_req(pcd_pkg::PCT_CHAR, 1'b0); add_req("4", 1'b0); add_req("1", 1'b1);
      // zero value passes through
      add_req(pcd_pkg::PCT_CHAR, 1'b0); add_req("0", 1'b0); add_req("0", 1'b1);
      // non-hex after '%'
      add_req(pcd_pkg::PCT_CHAR, 1'b0); add_req("g", 1'b0); add_req("1", 1'b1);
      // second '%' reopens the escape
      add_req(pcd_pkg::PCT_CHAR, 1'b0); add_req(pcd_pkg::PCT_CHAR, 1'b0);
      add_req("f", 1'b0); add_req("F", 1'b1);
      // '%' after one digit reopens the escape
      add_req(pcd_pkg::PCT_CHAR, 1'b0); add_req("4", 1'b0);
      add_req(pcd_pkg::PCT_CHAR, 1'b0); add_req("2", 1'b0); add_req("a", 1'b1);
      // '%' with last, and cut-short escapes
      add_req(pcd_pkg::PCT_CHAR, 1'b1);
      add_req(pcd_pkg::PCT_CHAR, 1'b0); add_req(pcd_pkg::PCT_CHAR, 1'b1);
      add_req(pcd_pkg::PCT_CHAR, 1'b0); add_req("7", 1'b0); add_req("x", 1'b1);
      // byte extremes
      add_req(8'h00, 1'b1);
      add_req(8'hff, 1'b1);

      target = pending_reqs.size() + RANDOM_ITEMS;
      while (pending_reqs.size() < target) begin
         if ($urandom_range(0, 9) == 0) begin
            // raw noise, last flag at random
            repeat ($urandom_range(1, 6)) begin
               add_req(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
         end else begin
            add_component();
         end
      end
      add_component();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || push || expected_bytes.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0 && expected_bytes.size() == 0) begin
         $display("percent_decoder_core regression: pass");
      end else begin
         $display("percent_decoder_core regression: fail");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/pcd_pkg.sv
hw/rtl/pcd_front.sv
hw/rtl/pcd_queue.sv
hw/rtl/pcd_back.sv
hw/rtl/percent_decoder_core.sv
dv/tb_percent_decoder_core.sv
